// File: hdl/frt_pkg.sv
`default_nettype none
package frt_pkg;

	// fixed field widths
	localparam int COUNT_W = 4;
	localparam int LEN_W = 8;
	localparam int TOTAL_W = 11;
	localparam int SLOT_OUT_W = 3;

	// most fragments one message may have
	localparam int MAX_PARTS = 8;
	localparam int PART_IDX_W = 3;

	typedef struct packed {
		logic [COUNT_W-1:0] frag_count;
		logic [COUNT_W-1:0] frag_number;
		logic [COUNT_W-1:0] seq_id;
		logic [LEN_W-1:0]   frag_length;
		logic               closing;
	} frt_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} frt_state_t;

endpackage
`default_nettype wire

// File: hdl/frt_front.sv
`default_nettype none
module frt_front (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [3:0]                frag_count,
	input  wire logic [3:0]                frag_number,
	input  wire logic [3:0]                seq_id,
	input  wire logic [7:0]                frag_length,
	output logic                           push_valid,
	input  wire logic                      push_ready,
	output frt_pkg::frt_item_t             push_item
);
	import frt_pkg::*;

	logic      valid_s1;
	frt_item_t item_s1;

	// stage is free when empty or when the queue takes it now
	assign in_ready = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// a fragment closes a message when its number equals its count
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.frag_count <= frag_count;
			item_s1.frag_number <= frag_number;
			item_s1.seq_id <= seq_id;
			item_s1.frag_length <= frag_length;
			item_s1.closing <= (frag_count == frag_number);
		end
	end

endmodule
`default_nettype wire

// File: hdl/frt_queue.sv
`default_nettype none
module frt_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push_valid,
	output logic                    push_ready,
	input  wire frt_pkg::frt_item_t push_item,
	output logic                    pop_valid,
	input  wire logic               pop,
	output frt_pkg::frt_item_t      pop_item
);
	import frt_pkg::*;

	frt_item_t entry_q [2];
	logic      wr_ptr_q;
	logic      rd_ptr_q;
	logic [1:0] fill_q;
	logic      do_push;
	logic      do_pop;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid = (fill_q != 2'd0);
	assign pop_item = entry_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

// File: hdl/frt_back.sv
`default_nettype none
module frt_back #(
	parameter int STACK_DEPTH = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               pop_valid,
	output logic                    pop,
	input  wire frt_pkg::frt_item_t pop_item,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    complete,
	output logic [2:0]              slot,
	output logic [7:0]              part_length,
	output logic [10:0]             total_length,
	output logic                    last
);
	import frt_pkg::*;

	localparam int SLOT_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int EXT_W = SLOT_W + SLOT_OUT_W;

	// fragment table
	logic [STACK_DEPTH-1:0] slot_valid_q;
	logic [COUNT_W-1:0]     slot_seq_q    [STACK_DEPTH];
	logic [COUNT_W-1:0]     slot_number_q [STACK_DEPTH];
	logic [COUNT_W-1:0]     slot_total_q  [STACK_DEPTH];
	logic [LEN_W-1:0]       slot_len_q    [STACK_DEPTH];
	logic [SLOT_W-1:0]      write_ptr_q;

	// search state
	frt_state_t           state_q;
	frt_state_t           state_d;
	logic [SLOT_W-1:0]    scan_q;
	logic [COUNT_W-1:0]   part_q;
	logic [COUNT_W-1:0]   need_q;
	logic [COUNT_W-1:0]   seq_q;
	logic [TOTAL_W-1:0]   total_q;
	logic                 fail_q;
	logic [SLOT_W-1:0]    written_q;
	logic [PART_IDX_W-1:0] emit_q;
	logic [SLOT_W-1:0]    found_slot_q [MAX_PARTS];
	logic [LEN_W-1:0]     found_len_q  [MAX_PARTS];

	// output register
	logic                 out_valid_q;

	logic                 hit;
	logic                 first_part;
	logic [COUNT_W-1:0]   hit_total;
	logic [COUNT_W-1:0]   need_eff;
	logic                 bad_need;
	logic                 scan_end;
	logic                 load_out;
	logic                 emit_last;
	logic [PART_IDX_W-1:0] part_idx;
	logic [EXT_W-1:0]     emit_slot_ext;
	logic [EXT_W-1:0]     written_ext;

	assign hit = slot_valid_q[scan_q] && (slot_seq_q[scan_q] == seq_q)
		&& (slot_number_q[scan_q] == part_q);
	assign first_part = (part_q == COUNT_W'(1));
	assign hit_total = slot_total_q[scan_q];
	assign need_eff = first_part ? hit_total : need_q;
	assign bad_need = first_part
		&& ((hit_total == '0) || (hit_total > COUNT_W'(MAX_PARTS)));
	assign scan_end = (scan_q == SLOT_W'(STACK_DEPTH - 1));
	assign part_idx = PART_IDX_W'(part_q - COUNT_W'(1));
	assign emit_slot_ext = EXT_W'(found_slot_q[emit_q]);
	assign written_ext = EXT_W'(written_q);
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (pop_valid && pop_item.closing) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (hit) begin
					if (bad_need || (part_q == need_eff)) begin
						state_d = ST_EMIT;
					end
				end else if (scan_end) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (load_out && emit_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control strobes
	always_comb begin
		pop = 1'b0;
		load_out = 1'b0;
		emit_last = fail_q
			|| (({1'b0, emit_q} + (PART_IDX_W+1)'(1)) == (PART_IDX_W+1)'(need_q));
		case (state_q)
			ST_IDLE: begin
				pop = pop_valid;
			end
			ST_EMIT: begin
				load_out = !out_valid_q || out_ready;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			slot_valid_q <= '0;
			write_ptr_q <= '0;
			scan_q <= '0;
			part_q <= '0;
			need_q <= '0;
			seq_q <= '0;
			total_q <= '0;
			fail_q <= 1'b0;
			written_q <= '0;
			emit_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				slot_valid_q[write_ptr_q] <= 1'b1;
				written_q <= write_ptr_q;
				write_ptr_q <= (write_ptr_q == SLOT_W'(STACK_DEPTH - 1)) ? '0
					: write_ptr_q + SLOT_W'(1);
				part_q <= COUNT_W'(1);
				need_q <= '0;
				scan_q <= '0;
				total_q <= '0;
				fail_q <= 1'b0;
				emit_q <= '0;
				seq_q <= pop_item.seq_id;
			end
			if (state_q == ST_SCAN) begin
				if (hit) begin
					if (first_part) begin
						need_q <= hit_total;
					end
					if (bad_need) begin
						fail_q <= 1'b1;
					end else begin
						total_q <= total_q + TOTAL_W'(slot_len_q[scan_q]);
						if (part_q != need_eff) begin
							part_q <= part_q + COUNT_W'(1);
							scan_q <= '0;
						end
					end
				end else if (scan_end) begin
					fail_q <= 1'b1;
				end else begin
					scan_q <= scan_q + SLOT_W'(1);
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
				emit_q <= emit_q + PART_IDX_W'(1);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// table contents, found list and result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			slot_seq_q[write_ptr_q] <= pop_item.seq_id;
			slot_number_q[write_ptr_q] <= pop_item.frag_number;
			slot_total_q[write_ptr_q] <= pop_item.frag_count;
			slot_len_q[write_ptr_q] <= pop_item.frag_length;
		end
		if ((state_q == ST_SCAN) && hit && !bad_need) begin
			found_slot_q[part_idx] <= scan_q;
			found_len_q[part_idx] <= slot_len_q[scan_q];
		end
		if (load_out) begin
			if (fail_q) begin
				complete <= 1'b0;
				slot <= written_ext[SLOT_OUT_W-1:0];
				part_length <= '0;
				total_length <= '0;
				last <= 1'b1;
			end else begin
				complete <= 1'b1;
				slot <= emit_slot_ext[SLOT_OUT_W-1:0];
				part_length <= found_len_q[emit_q];
				total_length <= total_q;
				last <= emit_last;
			end
		end
	end

endmodule
`default_nettype wire

// File: hdl/fragment_reassembly_table_unit.sv
// fragment reassembly table
// input channel (in_valid/in_ready): one message fragment per item, carrying
// frag_count, frag_number, seq_id and frag_length. output channel
// (out_valid/out_ready): result items with complete, slot, part_length,
// total_length and last.
// a fragment whose number differs from its count only lands in the table and
// gives no result. a closing fragment starts a search that walks the table
// one slot per cycle for each fragment number up to the count stored with
// fragment one, then emits one result item per fragment found; a failed
// search gives one item with complete low and last high.
// a non-closing fragment passes the table stage without a search; a two-entry
// queue and an input register let the input side take up to three fragments
// while a search is running or while the output is stalled.
// reset clears the slot valid bits, the write pointer, the queue and the
// output valid bit; the table holds no message after reset.
// a stalled receiver holds the result register, which stops the search engine
// and, once the queue and the input register are full, drops in_ready.
`default_nettype none
module fragment_reassembly_table_unit #(
	parameter int STACK_DEPTH = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [3:0]  frag_count,
	input  wire logic [3:0]  frag_number,
	input  wire logic [3:0]  seq_id,
	input  wire logic [7:0]  frag_length,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             complete,
	output logic [2:0]       slot,
	output logic [7:0]       part_length,
	output logic [10:0]      total_length,
	output logic             last
);
	import frt_pkg::*;

	// front register to queue
	logic      push_valid;
	logic      push_ready;
	frt_item_t push_item;

	// queue to search engine
	logic      pop_valid;
	logic      pop;
	frt_item_t pop_item;

	// accept and classify each fragment
	frt_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.frag_count  (frag_count),
		.frag_number (frag_number),
		.seq_id      (seq_id),
		.frag_length (frag_length),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_item   (push_item)
	);

	// short decoupling queue
	frt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_item   (pop_item)
	);

	// table, search and result emission
	frt_back #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop          (pop),
		.pop_item     (pop_item),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.complete     (complete),
		.slot         (slot),
		.part_length  (part_length),
		.total_length (total_length),
		.last         (last)
	);

endmodule
`default_nettype wire

// File: verif/frt_scoreboard_pkg.sv
package frt_scoreboard_pkg;
	import frt_pkg::*;

	localparam int TABLE_DEPTH = 8;

	typedef struct packed {
		logic                  complete;
		logic [SLOT_OUT_W-1:0] slot;
		logic [LEN_W-1:0]      part_length;
		logic [TOTAL_W-1:0]    total_length;
		logic                  last;
	} frag_result_t;

	class reassembly_scoreboard;
		bit                 slot_used [TABLE_DEPTH];
		logic [COUNT_W-1:0] slot_seq [TABLE_DEPTH];
		logic [COUNT_W-1:0] slot_num [TABLE_DEPTH];
		logic [COUNT_W-1:0] slot_cnt [TABLE_DEPTH];
		logic [LEN_W-1:0]   slot_len [TABLE_DEPTH];
		int unsigned        wr_ptr;
		frag_result_t       expected_q [$];
		int                 mismatches;
		int                 results_checked;
		int                 messages_done;
		int                 closures_failed;

		function new();
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				slot_used[i] = 1'b0;
				slot_seq[i] = '0;
				slot_num[i] = '0;
				slot_cnt[i] = '0;
				slot_len[i] = '0;
			end
			wr_ptr = 0;
			mismatches = 0;
			results_checked = 0;
			messages_done = 0;
			closures_failed = 0;
		endfunction

		// lowest valid slot with this id and number, TABLE_DEPTH if none
		function int find_fragment(input logic [COUNT_W-1:0] seq,
				input logic [COUNT_W-1:0] number);
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				if (slot_used[i] && slot_seq[i] == seq && slot_num[i] == number)
					return i;
			end
			return TABLE_DEPTH;
		endfunction

		function void note_fragment(input logic [COUNT_W-1:0] count,
				input logic [COUNT_W-1:0] number, input logic [COUNT_W-1:0] seq,
				input logic [LEN_W-1:0] len);
			int                 w;
			int                 first;
			int                 need;
			int                 n;
			int                 s;
			int                 hits [MAX_PARTS];
			logic [TOTAL_W-1:0] sum;
			bit                 ok;
			frag_result_t       r;
			w = wr_ptr;
			slot_used[w] = 1'b1;
			slot_seq[w] = seq;
			slot_num[w] = number;
			slot_cnt[w] = count;
			slot_len[w] = len;
			wr_ptr = (w + 1) % TABLE_DEPTH;
			if (count != number)
				return;
			ok = 1'b0;
			sum = '0;
			need = 0;
			first = find_fragment(seq, 4'd1);
			if (first < TABLE_DEPTH) begin
				// the stored count of fragment one rules, not the closing one
				need = slot_cnt[first];
				if (need >= 1 && need <= MAX_PARTS) begin
					ok = 1'b1;
					for (n = 1; n <= need && ok; n++) begin
						s = (n == 1) ? first : find_fragment(seq, 4'(n));
						if (s >= TABLE_DEPTH) begin
							ok = 1'b0;
						end else begin
							hits[n-1] = s;
							sum += slot_len[s];
						end
					end
				end
			end
			if (!ok) begin
				r.complete = 1'b0;
				r.slot = 3'(w);
				r.part_length = '0;
				r.total_length = '0;
				r.last = 1'b1;
				expected_q.push_back(r);
				closures_failed++;
				return;
			end
			for (n = 0; n < need; n++) begin
				r.complete = 1'b1;
				r.slot = 3'(hits[n]);
				r.part_length = slot_len[hits[n]];
				r.total_length = sum;
				r.last = (n == need - 1);
				expected_q.push_back(r);
			end
			messages_done++;
		endfunction

		function void compare_field(input string name, input logic [TOTAL_W-1:0] want,
				input logic [TOTAL_W-1:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(input frag_result_t got);
			frag_result_t want;
			results_checked++;
			if (expected_q.size() == 0) begin
				$error("unexpected result item: complete %0d slot %0d part %0d total %0d",
					got.complete, got.slot, got.part_length, got.total_length);
				mismatches++;
				return;
			end
			want = expected_q.pop_front();
			compare_field("complete", want.complete, got.complete);
			compare_field("slot", want.slot, got.slot);
			compare_field("part_length", want.part_length, got.part_length);
			compare_field("total_length", want.total_length, got.total_length);
			compare_field("last", want.last, got.last);
		endfunction
	endclass

endpackage

// File: verif/fragment_reassembly_table_unit_tb.sv
module fragment_reassembly_table_unit_tb;
	import frt_pkg::*;
	import frt_scoreboard_pkg::*;

	// stimulus stops once this many fragments have gone in
	localparam int FRAGMENT_TARGET = 470;
	// drain well past a full scan of the table and the pipeline
	localparam int DRAIN_CYCLES = 200;
	// cycles with no item moving on either side before giving up
	localparam int WATCHDOG_LIMIT = 1000;

	typedef enum {
		MSG_WHOLE,
		MSG_MISSING,
		MSG_EARLY_CLOSE
	} msg_style_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [3:0]  frag_count = '0;
	logic [3:0]  frag_number = '0;
	logic [3:0]  seq_id = '0;
	logic [7:0]  frag_length = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        complete;
	logic [2:0]  slot;
	logic [7:0]  part_length;
	logic [10:0] total_length;
	logic        last;

	// when set, both sides run flat out with no idle cycles
	bit calm = 1'b0;
	int fragments_sent = 0;
	int idle_cycles = 0;

	reassembly_scoreboard sb = new();

	fragment_reassembly_table_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.frag_count  (frag_count),
		.frag_number (frag_number),
		.seq_id      (seq_id),
		.frag_length (frag_length),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.complete    (complete),
		.slot        (slot),
		.part_length (part_length),
		.total_length(total_length),
		.last        (last)
	);

	always begin
		#4;
		clk = 1'b1;
		#4;
		clk = 1'b0;
	end

	// one fragment: optional idle gap, then hold valid until the block takes it
	task automatic send_fragment(input logic [3:0] count, input logic [3:0] number,
			input logic [3:0] seq, input logic [7:0] len);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		frag_count <= count;
		frag_number <= number;
		seq_id <= seq;
		frag_length <= len;
		do @(posedge clk); while (!in_ready);
		// predictor sees the fragment in the order the table stores it
		sb.note_fragment(count, number, seq, len);
		fragments_sent++;
	endtask

	// a message of count fragments; the style decides how well formed it is
	task automatic send_message(input msg_style_t style, input logic [3:0] seq,
			input int count);
		int order [$];
		int k;
		int j;
		int tmp;
		for (k = 1; k < count; k++)
			order.push_back(k);
		// leading fragments in any order, as the table does not care
		for (k = order.size() - 1; k > 0; k--) begin
			j = $urandom_range(0, k);
			tmp = order[k];
			order[k] = order[j];
			order[j] = tmp;
		end
		if (style == MSG_MISSING && order.size() > 0)
			order.delete($urandom_range(0, order.size() - 1));
		// closing fragment normally last; an early close lands anywhere
		if (style == MSG_EARLY_CLOSE)
			order.insert($urandom_range(0, order.size()), count);
		else
			order.push_back(count);
		foreach (order[i])
			send_fragment(4'(count), 4'(order[i]), seq, 8'($urandom_range(0, 255)));
	endtask

	// result side: random back-pressure, one draw per result item
	initial begin
		int gap;
		while (!arst_n) @(posedge clk);
		forever begin
			gap = calm ? 0 : $urandom_range(0, 5);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// compare every result item taken by the receiver
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result('{complete, slot, part_length, total_length, last});
	end

	// progress watchdog: any item moving on either side resets the count
	initial begin
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("watchdog: no progress for %0d cycles, %0d result items outstanding",
			WATCHDOG_LIMIT, sb.expected_q.size());
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int roll;
		int noise;
		logic [3:0] c;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed part
		// single-fragment messages at both length extremes
		send_fragment(4'd1, 4'd1, 4'd0, 8'd0);
		send_fragment(4'd1, 4'd1, 4'd15, 8'd255);
		// count and number both zero still searches for fragment one
		send_fragment(4'd0, 4'd0, 4'd3, 8'd17);
		// two-fragment message, full lengths
		send_fragment(4'd2, 4'd1, 4'd5, 8'd255);
		send_fragment(4'd2, 4'd2, 4'd5, 8'd255);
		// closing fragment with no fragment one in the table
		send_fragment(4'd3, 4'd3, 4'd7, 8'd42);
		// fragment one stored with count zero
		send_fragment(4'd0, 4'd1, 4'd9, 8'd1);
		send_fragment(4'd2, 4'd2, 4'd9, 8'd2);
		// fragment one claims more parts than a message may have
		send_fragment(4'd15, 4'd1, 4'd10, 8'd128);
		send_fragment(4'd2, 4'd2, 4'd10, 8'd64);
		// counts disagree: fragment one says two, the closer says three
		send_fragment(4'd2, 4'd1, 4'd12, 8'd7);
		send_fragment(4'd5, 4'd2, 4'd12, 8'd8);
		send_fragment(4'd3, 4'd3, 4'd12, 8'd9);
		// largest message fills the whole table, total at its maximum
		for (int n = 1; n <= MAX_PARTS; n++)
			send_fragment(4'(MAX_PARTS), 4'(n), 4'd1, 8'd255);
		// closer for a nine-part message, written over fragment one of the eight-part one
		send_fragment(4'd9, 4'd9, 4'd1, 8'd170);

		// random part: mostly proper messages, with broken ones and noise mixed in
		while (fragments_sent < FRAGMENT_TARGET) begin
			calm = ($urandom_range(0, 4) == 0);
			roll = $urandom_range(0, 99);
			if (roll < 60) begin
				send_message(MSG_WHOLE, 4'($urandom_range(0, 9)), $urandom_range(1, 8));
			end else if (roll < 72) begin
				send_message(MSG_MISSING, 4'($urandom_range(0, 9)), $urandom_range(2, 8));
			end else if (roll < 84) begin
				send_message(MSG_EARLY_CLOSE, 4'($urandom_range(0, 9)),
					$urandom_range(2, 8));
			end else if (roll < 94) begin
				// stray fragments over the full field ranges
				noise = $urandom_range(1, 3);
				repeat (noise)
					send_fragment(4'($urandom), 4'($urandom), 4'($urandom),
						8'($urandom));
			end else begin
				// stray closer with any count, zero and oversize included
				c = 4'($urandom);
				send_fragment(c, c, 4'($urandom), 8'($urandom));
			end
		end
		in_valid <= 1'b0;

		// let every expected result come out, then watch for strays
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d fragments sent: %0d messages reassembled, %0d closures incomplete",
			fragments_sent, sb.messages_done, sb.closures_failed);
		$display("%0d result items checked, %0d mismatches",
			sb.results_checked, sb.mismatches);
		if (sb.mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: fragment_reassembly_table_unit.f
hdl/frt_pkg.sv
hdl/frt_front.sv
hdl/frt_queue.sv
hdl/frt_back.sv
hdl/fragment_reassembly_table_unit.sv
verif/frt_scoreboard_pkg.sv
verif/fragment_reassembly_table_unit_tb.sv
